>>> src/key_slot_table_with_frame_sweep_top_assert.svh
// Assertion macros for the key slot table.
`ifndef KEY_SLOT_TABLE_WITH_FRAME_SWEEP_TOP_ASSERT_SVH
`define KEY_SLOT_TABLE_WITH_FRAME_SWEEP_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KSTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ksts_pkg.sv
// Shared types and constants for the key slot table.
package ksts_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned SlotW = 7;
  localparam int unsigned StatW = 3;
  localparam int unsigned CmdW  = 2;

  localparam logic [SlotW-1:0] SlotBaseRst  = 7'd105;
  localparam logic [SlotW-1:0] SlotLimitRst = 7'd126;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_END    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_HIT   = 3'd0,
    ST_NEW   = 3'd1,
    ST_FULL  = 3'd2,
    ST_FREED = 3'd3,
    ST_DONE  = 3'd4,
    ST_ZERO  = 3'd5
  } status_e;

  typedef enum logic {
    REG_SLOT_BASE  = 1'b0,
    REG_SLOT_LIMIT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             over_limit;
    logic             key_match;
  } unit_res_t;

endpackage

>>> src/ksts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ksts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 22,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ksts_slot_unit.sv
// Shared slot adder, limit compare and key compare.
module ksts_slot_unit #(
  parameter int unsigned IDX_W = 5
) (
  input  logic [ksts_pkg::SlotW-1:0] slot_base_i,
  input  logic [ksts_pkg::SlotW-1:0] slot_limit_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [ksts_pkg::KeyW-1:0]  key_a_i,
  input  logic [ksts_pkg::KeyW-1:0]  key_b_i,
  output ksts_pkg::unit_res_t        res_o
);
  import ksts_pkg::*;

  logic [SlotW:0] sum;

  assign sum = {1'b0, slot_base_i} + (SlotW + 1)'(idx_i);

  always_comb begin
    res_o.slot       = sum[SlotW-1:0];
    res_o.over_limit = sum > {1'b0, slot_limit_i};
    res_o.key_match  = key_a_i == key_b_i;
  end

endmodule

>>> src/key_slot_table_with_frame_sweep_top.sv
// Top level of the key slot table with frame sweep.
// A lookup scans the table one entry per cycle through the key RAM read port:
// a hit is reported once the matching key is compared, else a new entry or
// full after the last entry. Begin frame and a zero-key lookup answer in the
// cycle after start. End frame and clear walk all ENTRIES entries, one per
// cycle, emitting a freed item on result_valid_o for each entry let go,
// then a done item with last_o set. Results come out once and cannot be held
// off. busy_o is high during a scan or sweep until its last item is shown,
// not for begin frame or a zero key. Configuration writes are always ready.
`include "key_slot_table_with_frame_sweep_top_assert.svh"

module key_slot_table_with_frame_sweep_top #(
  parameter int unsigned ENTRIES = 22
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [ksts_pkg::CmdW-1:0]   command_i,
  input  logic [ksts_pkg::KeyW-1:0]   key_i,
  output logic                        result_valid_o,
  output logic [ksts_pkg::StatW-1:0]  status_o,
  output logic [ksts_pkg::SlotW-1:0]  slot_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [ksts_pkg::SlotW-1:0]  cfg_data_i
);
  import ksts_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_SWEEP,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pend_idx_q, pend_idx_d;
  logic              empty_found_q, empty_found_d;
  logic [IW-1:0]     empty_idx_q, empty_idx_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic              clr_all_q, clr_all_d;
  logic [ENTRIES-1:0] occ_q, occ_d;
  logic [ENTRIES-1:0] seen_q, seen_d;
  logic              res_valid_q, res_valid_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              last_q, last_d;
  logic [SlotW-1:0]  slot_base_q, slot_limit_q;

  logic              ram_we;
  logic [KeyW-1:0]   ram_rdata;
  logic [IW-1:0]     unit_idx;
  unit_res_t         unit_res;
  logic              accept;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_base_q  <= SlotBaseRst;
      slot_limit_q <= SlotLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SLOT_BASE:  slot_base_q  <= cfg_data_i;
        REG_SLOT_LIMIT: slot_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ksts_ram #(
    .WIDTH (KeyW),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (empty_idx_q),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (state_q)
      S_SCAN:  unit_idx = pend_idx_q;
      S_ALLOC: unit_idx = empty_idx_q;
      default: unit_idx = idx_q;
    endcase
  end

  ksts_slot_unit #(
    .IDX_W (IW)
  ) u_slot_unit (
    .slot_base_i  (slot_base_q),
    .slot_limit_i (slot_limit_q),
    .idx_i        (unit_idx),
    .key_a_i      (ram_rdata),
    .key_b_i      (key_q),
    .res_o        (unit_res)
  );

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    pend_d        = 1'b0;
    pend_idx_d    = pend_idx_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    key_d         = key_q;
    clr_all_d     = clr_all_q;
    occ_d         = occ_q;
    seen_d        = seen_q;
    res_valid_d   = 1'b0;
    status_d      = status_q;
    slot_d        = slot_q;
    last_d        = last_q;
    ram_we        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(command_i))
            CMD_LOOKUP: begin
              if (key_i == '0) begin
                res_valid_d = 1'b1;
                status_d    = ST_ZERO;
                slot_d      = '0;
                last_d      = 1'b1;
              end else begin
                key_d         = key_i;
                idx_d         = '0;
                empty_found_d = 1'b0;
                state_d       = S_SCAN;
              end
            end
            CMD_BEGIN: begin
              seen_d      = '0;
              res_valid_d = 1'b1;
              status_d    = ST_DONE;
              slot_d      = '0;
              last_d      = 1'b1;
            end
            CMD_END: begin
              clr_all_d = 1'b0;
              idx_d     = '0;
              state_d   = S_SWEEP;
            end
            CMD_CLEAR: begin
              clr_all_d = 1'b1;
              seen_d    = '0;
              idx_d     = '0;
              state_d   = S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (pend_q && occ_q[pend_idx_q] && unit_res.key_match) begin
          seen_d[pend_idx_q] = 1'b1;
          res_valid_d        = 1'b1;
          status_d           = ST_HIT;
          slot_d             = unit_res.slot;
          last_d             = 1'b1;
          state_d            = S_IDLE;
        end else begin
          if (pend_q && !occ_q[pend_idx_q] && !empty_found_q) begin
            empty_found_d = 1'b1;
            empty_idx_d   = pend_idx_q;
          end
          if (pend_q && (pend_idx_q == LastIdx)) begin
            state_d = S_ALLOC;
          end else begin
            pend_d     = 1'b1;
            pend_idx_d = idx_q;
            idx_d      = idx_q + 1'b1;
          end
        end
      end
      S_ALLOC: begin
        res_valid_d = 1'b1;
        last_d      = 1'b1;
        state_d     = S_IDLE;
        if (!empty_found_q || unit_res.over_limit) begin
          status_d = ST_FULL;
          slot_d   = '0;
        end else begin
          ram_we              = 1'b1;
          occ_d[empty_idx_q]  = 1'b1;
          seen_d[empty_idx_q] = 1'b1;
          status_d            = ST_NEW;
          slot_d              = unit_res.slot;
        end
      end
      S_SWEEP: begin
        if (occ_q[idx_q] && (clr_all_q || !seen_q[idx_q])) begin
          occ_d[idx_q] = 1'b0;
          res_valid_d  = 1'b1;
          status_d     = ST_FREED;
          slot_d       = unit_res.slot;
          last_d       = 1'b0;
        end
        if (idx_q == LastIdx) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        res_valid_d = 1'b1;
        status_d    = ST_DONE;
        slot_d      = '0;
        last_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      pend_q        <= 1'b0;
      pend_idx_q    <= '0;
      empty_found_q <= 1'b0;
      empty_idx_q   <= '0;
      key_q         <= '0;
      clr_all_q     <= 1'b0;
      occ_q         <= '0;
      seen_q        <= '0;
      res_valid_q   <= 1'b0;
      status_q      <= '0;
      slot_q        <= '0;
      last_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      pend_q        <= pend_d;
      pend_idx_q    <= pend_idx_d;
      empty_found_q <= empty_found_d;
      empty_idx_q   <= empty_idx_d;
      key_q         <= key_d;
      clr_all_q     <= clr_all_d;
      occ_q         <= occ_d;
      seen_q        <= seen_d;
      res_valid_q   <= res_valid_d;
      status_q      <= status_d;
      slot_q        <= slot_d;
      last_q        <= last_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign last_o         = last_q;

  `KSTS_ASSERT_NOW(a_more_follows, res_valid_q && !last_q, busy_o, "item without last while idle")
  `KSTS_ASSERT_NEXT(a_lookup_busy, accept && (command_i == CMD_LOOKUP) && (key_i != '0), busy_o, "lookup did not start a scan")
  `KSTS_ASSERT_NEXT(a_occ_only_alloc, state_q != S_ALLOC, (occ_q & ~$past(occ_q)) == '0, "entry claimed outside allocation")
  `KSTS_ASSERT_NOW(a_freed_not_last, res_valid_q && (status_q == ST_FREED), !last_q, "freed item marked last")

endmodule
